// ===== hw/rtl/mmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc_pkg
// Shared types and constants of the magnetometer min/max calibrator.
// ----------------------------------------------------------------------------
package mmc_pkg;

   localparam int AXIS_COUNT = 3;
   localparam int SAMPLE_W   = 16;
   localparam int OFFSET_W   = SAMPLE_W + 1;
   localparam int SPAN_W     = SAMPLE_W + 1;
   localparam int SUM_W      = SAMPLE_W + 3;
   localparam int SCALE_W    = 16;
   localparam int COUNT_W    = 32;
   localparam int AXIS_W     = 2;
   localparam int FRAC_W     = 12;

   // serial divider: numerator sum * 4096, denominator 3 * span
   localparam int NUM_W  = SUM_W - 1 + FRAC_W;
   localparam int DEN_W  = SAMPLE_W + 2;
   localparam int STEP_W = $clog2(NUM_W);

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

   localparam logic signed [SAMPLE_W-1:0] MIN_RESET = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] MAX_RESET = 16'sh8000;
   localparam logic [SCALE_W-1:0]         SCALE_ONE = 16'd4096;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_SETUP,
      ST_DIVIDE,
      ST_EMIT
   } mmc_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mmc_div_status_type;

endpackage

// ===== hw/rtl/mmc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc_if
// Valid/ready channels of the calibrator: sample/finish requests and
// per-axis calibration responses.
// ----------------------------------------------------------------------------
interface mmc_req_if import mmc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic signed [SAMPLE_W-1:0] sample_x;
   logic signed [SAMPLE_W-1:0] sample_y;
   logic signed [SAMPLE_W-1:0] sample_z;

   modport source (output valid, kind, sample_x, sample_y, sample_z, input ready);
   modport sink   (input valid, kind, sample_x, sample_y, sample_z, output ready);
endinterface

interface mmc_rsp_if import mmc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [AXIS_W-1:0]          axis;
   logic signed [SAMPLE_W-1:0] min_value;
   logic signed [SAMPLE_W-1:0] max_value;
   logic signed [OFFSET_W-1:0] offset_twice;
   logic [SCALE_W-1:0]         scale_q12;
   logic [COUNT_W-1:0]         sample_count;
   logic                       last;

   modport source (output valid, axis, min_value, max_value, offset_twice, scale_q12,
                   sample_count, last, input ready);
   modport sink   (input valid, axis, min_value, max_value, offset_twice, scale_q12,
                   sample_count, last, output ready);
endinterface

// ===== hw/rtl/mmc_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmc_divider import mmc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NUM_W-1:0]   dividend,
   input  logic [DEN_W-1:0]   divisor,
   output logic [NUM_W-1:0]   quotient,
   output mmc_div_status_type status
);

   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              fits;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[NUM_W-2:0], fits};
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== hw/rtl/magnetometer_minmax_calibrator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_minmax_calibrator
// Min/max hard-iron and soft-iron calibration of a three-axis magnetometer.
// ----------------------------------------------------------------------------
// Sample transfers are taken one per cycle while collecting: each updates the
// per-axis minimum and maximum and a saturating sample count, and gives no
// response. A finish transfer stops collection for good (until reset); later
// samples are taken and ignored. The finish then produces three responses, X,
// Y and Z, the last flagged by last. For each axis with a positive span the scale
// comes from a serial divider that retires one quotient bit per cycle, and any
// response back-pressure holds the report; the request side is not ready until
// the Z response has been loaded into the response register. A finish after
// finish repeats the same report.
// ----------------------------------------------------------------------------
module magnetometer_minmax_calibrator import mmc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mmc_req_if.sink   req_ch,
   mmc_rsp_if.source rsp_ch
);

   mmc_state_type              state_ff, state_in;
   logic                       stopped_ff, stopped_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic signed [SAMPLE_W-1:0] min_ff [AXIS_COUNT];
   logic signed [SAMPLE_W-1:0] min_in [AXIS_COUNT];
   logic signed [SAMPLE_W-1:0] max_ff [AXIS_COUNT];
   logic signed [SAMPLE_W-1:0] max_in [AXIS_COUNT];
   logic [AXIS_W-1:0]          axis_ff, axis_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [SCALE_W-1:0]         scale_ff, scale_in;

   logic                       rsp_valid_ff;
   logic [AXIS_W-1:0]          rsp_axis_ff;
   logic signed [SAMPLE_W-1:0] rsp_min_ff, rsp_max_ff;
   logic signed [OFFSET_W-1:0] rsp_offset_ff;
   logic [SCALE_W-1:0]         rsp_scale_ff;
   logic [COUNT_W-1:0]         rsp_count_ff;
   logic                       rsp_last_ff;

   logic                       req_xfer;
   logic                       slot_free;
   logic                       rsp_load;
   logic                       div_start;
   logic signed [SAMPLE_W-1:0] sample [AXIS_COUNT];
   logic signed [SPAN_W-1:0]   span [AXIS_COUNT];
   logic signed [SAMPLE_W-1:0] sel_min, sel_max;
   logic signed [SPAN_W-1:0]   sel_span;
   logic [DEN_W-1:0]           denom;
   logic [NUM_W-1:0]           numer;
   logic [NUM_W-1:0]           quotient;
   mmc_div_status_type         div_status;

   assign sample[0] = req_ch.sample_x;
   assign sample[1] = req_ch.sample_y;
   assign sample[2] = req_ch.sample_z;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
         span[i] = SPAN_W'(max_ff[i]) - SPAN_W'(min_ff[i]);
      end
   end

   assign sel_min  = min_ff[axis_ff];
   assign sel_max  = max_ff[axis_ff];
   assign sel_span = span[axis_ff];
   // 3 * span, span known positive here
   assign denom    = {1'b0, sel_span[SAMPLE_W-1:0], 1'b0} + {2'b00, sel_span[SAMPLE_W-1:0]};
   assign numer    = {sum_ff[SUM_W-2:0], {FRAC_W{1'b0}}};

   mmc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (numer),
      .divisor  (denom),
      .quotient (quotient),
      .status   (div_status)
   );

   always_comb begin
      state_in   = state_ff;
      stopped_in = stopped_ff;
      count_in   = count_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      axis_in    = axis_ff;
      sum_in     = sum_ff;
      scale_in   = scale_ff;
      rsp_load   = 1'b0;
      div_start  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_ch.kind == KIND_FINISH) begin
                  stopped_in = 1'b1;
                  axis_in    = AXIS_X;
                  state_in   = ST_SUM;
               end else if (!stopped_ff) begin
                  for (int i = 0; i < AXIS_COUNT; i++) begin
                     if (sample[i] < min_ff[i]) min_in[i] = sample[i];
                     if (sample[i] > max_ff[i]) max_in[i] = sample[i];
                  end
                  if (count_ff != '1) count_in = count_ff + 1'b1;
               end
            end
         end
         ST_SUM: begin
            sum_in   = SUM_W'(span[0]) + SUM_W'(span[1]) + SUM_W'(span[2]);
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            if (sel_span <= 0) begin
               scale_in = SCALE_ONE;
               state_in = ST_EMIT;
            end else if (sum_ff <= 0) begin
               scale_in = '0;
               state_in = ST_EMIT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               scale_in = (|quotient[NUM_W-1:SCALE_W]) ? '1 : quotient[SCALE_W-1:0];
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               if (axis_ff == AXIS_Z) begin
                  state_in = ST_IDLE;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = ST_SETUP;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stopped_ff   <= 1'b0;
         count_ff     <= '0;
         axis_ff      <= AXIS_X;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < AXIS_COUNT; i++) begin
            min_ff[i] <= MIN_RESET;
            max_ff[i] <= MAX_RESET;
         end
      end else begin
         state_ff   <= state_in;
         stopped_ff <= stopped_in;
         count_ff   <= count_in;
         axis_ff    <= axis_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      sum_ff   <= sum_in;
      scale_ff <= scale_in;
      if (rsp_load) begin
         rsp_axis_ff   <= axis_ff;
         rsp_min_ff    <= sel_min;
         rsp_max_ff    <= sel_max;
         rsp_offset_ff <= OFFSET_W'(sel_max) + OFFSET_W'(sel_min);
         rsp_scale_ff  <= scale_ff;
         rsp_count_ff  <= count_ff;
         rsp_last_ff   <= (axis_ff == AXIS_Z);
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.axis         = rsp_axis_ff;
   assign rsp_ch.min_value    = rsp_min_ff;
   assign rsp_ch.max_value    = rsp_max_ff;
   assign rsp_ch.offset_twice = rsp_offset_ff;
   assign rsp_ch.scale_q12    = rsp_scale_ff;
   assign rsp_ch.sample_count = rsp_count_ff;
   assign rsp_ch.last         = rsp_last_ff;

   a_stopped_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(stopped_ff))
      else $error("collection restarted without reset");

   a_finish_stops: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_ch.kind == KIND_FINISH) |=> (stopped_ff && state_ff == ST_SUM))
      else $error("finish did not start a report");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (min_ff[0] <= max_ff[0] && min_ff[1] <= max_ff[1]
                            && min_ff[2] <= max_ff[2]))
      else $error("axis minimum above maximum after samples");

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (!div_status.busy && state_ff == ST_SETUP))
      else $error("divider started while busy");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> slot_free)
      else $error("response register overwritten");

endmodule

// ===== test/mmc_report_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc_report_checker
// Tracks the calibrator's min/max state from request transfers and checks
// every response transfer against the predicted per-axis report.
// ----------------------------------------------------------------------------
// Sample transfers update a private copy of the per-axis extremes and the
// saturating count until the first finish. Each finish queues three reports,
// X, Y and Z. Responses are compared field by field with the oldest report.
// ----------------------------------------------------------------------------
module mmc_report_checker import mmc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mmc_req_if          req_mon,
   mmc_rsp_if          rsp_mon,
   output int unsigned mismatch_count,
   output int unsigned pending_count,
   output int unsigned checked_count
);

   typedef struct packed {
      logic [AXIS_W-1:0]          axis;
      logic signed [SAMPLE_W-1:0] min_value;
      logic signed [SAMPLE_W-1:0] max_value;
      logic signed [OFFSET_W-1:0] offset_twice;
      logic [SCALE_W-1:0]         scale_q12;
      logic [COUNT_W-1:0]         sample_count;
      logic                       last;
   } axis_report_type;

   localparam logic [AXIS_W-1:0] AXIS_CODE [AXIS_COUNT] = '{AXIS_X, AXIS_Y, AXIS_Z};
   localparam longint SCALE_CEIL = (longint'(1) << SCALE_W) - 1;

   logic signed [SAMPLE_W-1:0] axis_lo [AXIS_COUNT];
   logic signed [SAMPLE_W-1:0] axis_hi [AXIS_COUNT];
   logic [COUNT_W-1:0]         collected;
   logic                       finished;
   axis_report_type            expected_reports [$];

   // min/max calibration: offset_twice = max + min, scale = mean span / axis span in Q12
   task automatic predict_calibration_report();
      longint          span [AXIS_COUNT];
      longint          span_sum;
      longint          quotient;
      axis_report_type entry;
      span_sum = 0;
      for (int i = 0; i < AXIS_COUNT; i++) begin
         span[i] = longint'(axis_hi[i]) - longint'(axis_lo[i]);
         span_sum += span[i];
      end
      for (int i = 0; i < AXIS_COUNT; i++) begin
         entry.axis         = AXIS_CODE[i];
         entry.min_value    = axis_lo[i];
         entry.max_value    = axis_hi[i];
         entry.offset_twice = OFFSET_W'(longint'(axis_hi[i]) + longint'(axis_lo[i]));
         if (span[i] <= 0) begin
            entry.scale_q12 = SCALE_ONE;
         end else if (span_sum <= 0) begin
            entry.scale_q12 = '0;
         end else begin
            quotient = (span_sum << FRAC_W) / (AXIS_COUNT * span[i]);
            if (quotient > SCALE_CEIL) quotient = SCALE_CEIL;
            entry.scale_q12 = SCALE_W'(quotient);
         end
         entry.sample_count = collected;
         entry.last         = (AXIS_CODE[i] == AXIS_Z);
         expected_reports.push_back(entry);
      end
   endtask

   task automatic check_field(string field, logic signed [63:0] want_v,
                              logic signed [63:0] got_v);
      if (want_v !== got_v) begin
         mismatch_count++;
         $display("[%0t] %s: expected %0d, actual %0d", $time, field, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      axis_report_type            want;
      logic signed [SAMPLE_W-1:0] reading [AXIS_COUNT];
      if (reset) begin
         for (int i = 0; i < AXIS_COUNT; i++) begin
            axis_lo[i] = MIN_RESET;
            axis_hi[i] = MAX_RESET;
         end
         collected = '0;
         finished  = 1'b0;
         expected_reports.delete();
         mismatch_count = 0;
         checked_count  = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_reports.size() == 0) begin
               mismatch_count++;
               $display("[%0t] response transfer with no report pending: axis %0d",
                        $time, rsp_mon.axis);
            end else begin
               want = expected_reports.pop_front();
               check_field("axis", want.axis, rsp_mon.axis);
               check_field("min_value", want.min_value, rsp_mon.min_value);
               check_field("max_value", want.max_value, rsp_mon.max_value);
               check_field("offset_twice", want.offset_twice, rsp_mon.offset_twice);
               check_field("scale_q12", want.scale_q12, rsp_mon.scale_q12);
               check_field("sample_count", want.sample_count, rsp_mon.sample_count);
               check_field("last", want.last, rsp_mon.last);
               checked_count++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.kind == KIND_FINISH) begin
               finished = 1'b1;
               predict_calibration_report();
            end else if (!finished) begin
               reading[0] = req_mon.sample_x;
               reading[1] = req_mon.sample_y;
               reading[2] = req_mon.sample_z;
               for (int i = 0; i < AXIS_COUNT; i++) begin
                  if (reading[i] < axis_lo[i]) axis_lo[i] = reading[i];
                  if (reading[i] > axis_hi[i]) axis_hi[i] = reading[i];
               end
               if (collected != '1) collected++;
            end
         end
      end
      pending_count = expected_reports.size();
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench top of the magnetometer min/max calibrator.
// ----------------------------------------------------------------------------
// One collection run: X sweeps its extremes and bit patterns while Y and Z
// stay in random windows of different width, so the scales land on small,
// mid and clamped values. Then repeated finishes with ignored samples in
// between. Random idle gaps and response stalls; mmc_report_checker does the
// checking.
// ----------------------------------------------------------------------------
module tb_top;
   import mmc_pkg::*;

   localparam int     CLOCK_HALF      = 4;
   localparam int     RESET_CYCLES    = 11;
   localparam int     COLLECT_ITEMS   = 290;
   localparam int     REPEAT_FINISHES = 20;
   localparam int     DRAIN_CYCLES    = 150;
   localparam longint CYCLE_LIMIT     = 200000;

   localparam logic signed [SAMPLE_W-1:0] DIRECTED_X [8] = '{
      16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
      16'sh5555, 16'shAAAA, 16'sh0001, 16'sh7FFE
   };

   logic        clock = 1'b0;
   logic        reset;
   longint      cycle_count = 0;
   bit          req_burst = 1'b0;
   bit          rsp_burst = 1'b0;
   int          rsp_stall = 0;
   int unsigned samples_sent = 0;
   int unsigned finishes_sent = 0;
   int unsigned ignored_sent = 0;
   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned checked_count;

   mmc_req_if req_ch ();
   mmc_rsp_if rsp_ch ();

   magnetometer_minmax_calibrator i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   mmc_report_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   always begin
      #(CLOCK_HALF) clock = 1'b1;
      #(CLOCK_HALF) clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(10, 48);
   endfunction

   always @(posedge clock) begin
      if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
      if (rsp_stall == 0 && !rsp_burst && $urandom_range(0, 3) == 0) rsp_stall = idle_gap();
      if (rsp_stall != 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // called in the time step of a rising edge; returns at the edge of the transfer
   task automatic send_item(logic kind, logic signed [SAMPLE_W-1:0] x,
                            logic signed [SAMPLE_W-1:0] y, logic signed [SAMPLE_W-1:0] z);
      int   gap;
      logic took;
      gap = req_burst ? 0 : idle_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.kind     <= kind;
      req_ch.sample_x <= x;
      req_ch.sample_y <= y;
      req_ch.sample_z <= z;
      do begin
         @(negedge clock);
         took = req_ch.ready;
         @(posedge clock);
      end while (!took);
      if ($urandom_range(0, 31) == 0) req_burst = !req_burst;
   endtask

   task automatic send_ignored_sample();
      send_item(KIND_SAMPLE, SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
      ignored_sent++;
   endtask

   initial begin
      int                         y_mid;
      int                         y_span;
      int                         z_mid;
      int                         z_span;
      logic signed [SAMPLE_W-1:0] sy;
      logic signed [SAMPLE_W-1:0] sz;
      req_ch.valid    <= 1'b0;
      req_ch.kind     <= KIND_SAMPLE;
      req_ch.sample_x <= '0;
      req_ch.sample_y <= '0;
      req_ch.sample_z <= '0;
      reset           <= 1'b1;
      y_mid  = int'($urandom_range(0, 40000)) - 20000;
      y_span = $urandom_range(1, 1500);
      z_mid  = int'($urandom_range(0, 20000)) - 10000;
      z_span = $urandom_range(1000, 20000);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_X[k]) begin
         sy = SAMPLE_W'(y_mid + (k % 3 - 1) * y_span);
         sz = SAMPLE_W'(z_mid - (k % 3 - 1) * z_span);
         send_item(KIND_SAMPLE, DIRECTED_X[k], sy, sz);
         samples_sent++;
      end

      for (int n = 0; n < COLLECT_ITEMS; n++) begin
         sy = SAMPLE_W'(y_mid + int'($urandom_range(0, 2 * y_span)) - y_span);
         sz = SAMPLE_W'(z_mid + int'($urandom_range(0, 2 * z_span)) - z_span);
         send_item(KIND_SAMPLE, SAMPLE_W'($urandom), sy, sz);
         samples_sent++;
      end

      // two finishes in a row, then extreme samples that must be ignored
      send_item(KIND_FINISH, '0, '0, '0);
      send_item(KIND_FINISH, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
      finishes_sent += 2;
      send_item(KIND_SAMPLE, 16'sh8000, 16'sh7FFF, 16'sh8000);
      send_item(KIND_SAMPLE, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
      ignored_sent += 2;

      for (int n = 2; n < REPEAT_FINISHES; n++) begin
         repeat ($urandom_range(0, 3)) send_ignored_sample();
         send_item(KIND_FINISH, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                   SAMPLE_W'($urandom));
         finishes_sent++;
      end
      req_ch.valid <= 1'b0;

      do @(negedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Collected %0d samples, then %0d finishes and %0d ignored samples",
               samples_sent, finishes_sent, ignored_sent);
      $display("Checked %0d per-axis calibration responses", checked_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
